// ----- src/time_averaged_particle_temperature_top_macros.svh -----
// ----------------------------------------------------------------------------
// Time averaged particle temperature: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TIME_AVERAGED_PARTICLE_TEMPERATURE_TOP_MACROS_SVH
`define TIME_AVERAGED_PARTICLE_TEMPERATURE_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TAPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TAPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tapt_pkg.sv -----
// ----------------------------------------------------------------------------
// Time averaged particle temperature: package
// Operation and register codes, stored record layouts and controller commands.
// ----------------------------------------------------------------------------
package tapt_pkg;

  localparam logic [1:0] OP_DEPOSIT    = 2'd0;
  localparam logic [1:0] OP_START_STEP = 2'd1;
  localparam logic [1:0] OP_FINISH     = 2'd2;

  localparam logic [1:0] CFG_SPECIES    = 2'd0;
  localparam logic [1:0] CFG_START_STEP = 2'd1;
  localparam logic [1:0] CFG_SCALE      = 2'd2;

  localparam int DivW  = 80;
  localparam int DenW  = 32;
  localparam int MulW  = 33;
  localparam int ProdW = 66;
  localparam int VsumW = 40;

  typedef struct packed {
    logic [31:0]             ws;
    logic [2:0][VsumW-1:0]   vs;
    logic [63:0]             ss;
  } step_t;

  typedef struct packed {
    logic [63:0]       ts;
    logic [2:0][63:0]  tv;
  } timed_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_LOAD, DP_TSTEP, DP_FETCH, DP_WV, DP_VACC, DP_SQACC,
    DP_SQLO, DP_SQHI, DP_DEPFIN, DP_WSTEP, DP_STEPCLR, DP_DIVA, DP_DIVT,
    DP_MEAN, DP_DTLO, DP_DTHI, DP_TACC, DP_AVG, DP_AA, DP_SQSUM, DP_SCHI,
    DP_SCLO, DP_TEMP, DP_ZTEMP, DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [1:0]  comp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       e_ok;
    logic       species_ok;
    logic       active;
    logic       ws_zero;
    logic       tt_zero;
    logic       div_busy;
    logic       ms_gt;
    logic       clr_last;
  } sts_t;

endpackage

// ----- src/tapt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module tapt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tapt_div.sv -----
// ----------------------------------------------------------------------------
// Time averaged particle temperature: divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tapt_div
  import tapt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [DivW-1:0] quo_o
);

  localparam int CntW = $clog2(DivW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] q_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [DenW:0]   rem_sh, rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, q_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[DivW-2:0], ge};
      rem_q <= ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = q_q;

endmodule

// ----- src/tapt_datapath.sv -----
// ----------------------------------------------------------------------------
// Time averaged particle temperature: datapath
// Configuration, per element sum memories, shared multiplier and divider.
// ----------------------------------------------------------------------------
module tapt_datapath
  import tapt_pkg::*;
#(
  parameter int NUM_ELEMENTS   = 1024,
  parameter int VELOCITY_WIDTH = 16,
  parameter int WEIGHT_WIDTH   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cmd_t                             cmd_i,
  output sts_t                             sts_o,
  input  logic                             cfg_valid_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic [1:0]                       operation_i,
  input  logic [9:0]                       element_index_i,
  input  logic [7:0]                       particle_species_i,
  input  logic [WEIGHT_WIDTH-1:0]          particle_weight_i,
  input  logic signed [VELOCITY_WIDTH-1:0] velocity_x_i,
  input  logic signed [VELOCITY_WIDTH-1:0] velocity_y_i,
  input  logic signed [VELOCITY_WIDTH-1:0] velocity_z_i,
  input  logic [15:0]                      step_length_i,
  input  logic [15:0]                      step_number_i,
  output logic                             result_valid_o,
  output logic [9:0]                       result_element_o,
  output logic [31:0]                      temperature_o,
  output logic                             empty_step_o
);

  localparam int AW  = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int SqW = 2 * VELOCITY_WIDTH;
  localparam logic signed [ProdW-1:0] VsMax =
    {{(ProdW - VsumW + 1){1'b0}}, {(VsumW - 1){1'b1}}};
  localparam logic signed [ProdW-1:0] VsMin = ~VsMax;

  function automatic logic [63:0] sat_add_u(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] sat_add_s(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] comb_sat(logic [63:0] hi, logic [63:0] lo);
    logic [64:0] s;
    s = {1'b0, hi[31:0], 32'd0} + {1'b0, lo};
    return (hi[63:32] != '0 || s[64]) ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] from_mag(logic neg, logic [63:0] m);
    if (!neg) begin
      return m[63] ? {1'b0, {63{1'b1}}} : m;
    end
    return m[63] ? {1'b1, 63'd0} : (~m + 64'd1);
  endfunction

  logic [7:0]                       species_q;
  logic [15:0]                      start_step_q;
  logic [31:0]                      scale_q;
  logic [31:0]                      tt_q;
  logic                             active_q;
  logic [AW-1:0]                    clr_q;
  logic                             res_valid_q;
  logic [9:0]                       res_elem_q;
  logic [31:0]                      res_temp_q;
  logic                             res_empty_q;

  logic [1:0]                       op_q;
  logic [9:0]                       elem_q;
  logic [7:0]                       spec_q;
  logic [WEIGHT_WIDTH-1:0]          w_q;
  logic signed [VELOCITY_WIDTH-1:0] v_q [3];
  logic [15:0]                      dt_q;
  logic [15:0]                      stepn_q;
  step_t                            step_q;
  timed_t                           timed_q;
  logic signed [ProdW-1:0]          prod_q;
  logic [63:0]                      tlo_q;
  logic [SqW-1:0]                   sq_q;
  logic [63:0]                      mval_q, msavg_q, a_q, sqsum_q;
  logic [31:0]                      temp_q;

  logic [AW-1:0]                    ram_addr;
  logic                             step_we, timed_we;
  step_t                            step_wdata, step_rdata;
  timed_t                           timed_wdata, timed_rdata;
  logic [MulW-1:0]                  mul_a, mul_b;
  logic signed [ProdW-1:0]          mul_p;
  logic [1:0]                       vi;
  logic signed [VELOCITY_WIDTH-1:0] v_sel;
  logic [63:0]                      sq64, diff, pcomb;
  logic [VsumW-1:0]                 vs_mag;
  logic [63:0]                      tv_mag;
  logic                             div_start, div_busy;
  logic [DivW-1:0]                  div_num, div_quo;
  logic [DenW-1:0]                  div_den;
  logic signed [ProdW-1:0]          vacc;
  logic [32:0]                      tt_sum, wsum, tsum;

  assign vi     = cmd_i.comp - 2'd1;
  assign v_sel  = v_q[cmd_i.comp];
  assign sq64   = 64'(sq_q);
  assign diff   = msavg_q - sqsum_q;
  assign pcomb  = comb_sat(prod_q[63:0], tlo_q);
  assign vs_mag = step_q.vs[vi][VsumW-1] ? (~step_q.vs[vi] + VsumW'(1)) : step_q.vs[vi];
  assign tv_mag = timed_q.tv[vi][63] ? (~timed_q.tv[vi] + 64'd1) : timed_q.tv[vi];
  assign vacc   = ProdW'($signed(step_q.vs[cmd_i.comp])) + prod_q;
  assign tt_sum = {1'b0, tt_q} + 33'(dt_q);
  assign wsum   = {1'b0, step_q.ws} + 33'(w_q);
  assign tsum   = {1'b0, tlo_q[31:0]} + {1'b0, prod_q[63:32]};
  assign mul_p  = $signed(mul_a) * $signed(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      DP_WV: begin
        mul_a = MulW'(w_q);
        mul_b = MulW'(v_sel);
      end
      DP_VACC: begin
        mul_a = MulW'(v_sel);
        mul_b = MulW'(v_sel);
      end
      DP_SQLO: begin
        mul_a = MulW'(sq64[31:0]);
        mul_b = MulW'(w_q);
      end
      DP_SQHI: begin
        mul_a = MulW'(sq64[63:32]);
        mul_b = MulW'(w_q);
      end
      DP_DTLO: begin
        mul_a = MulW'(dt_q);
        mul_b = MulW'(mval_q[31:0]);
      end
      DP_DTHI: begin
        mul_a = MulW'(dt_q);
        mul_b = MulW'(mval_q[63:32]);
      end
      DP_AA: begin
        mul_a = MulW'(a_q[31:0]);
        mul_b = MulW'(a_q[31:0]);
      end
      DP_SCHI: begin
        mul_a = MulW'(diff[63:32]);
        mul_b = MulW'(scale_q);
      end
      DP_SCLO: begin
        mul_a = MulW'(diff[31:0]);
        mul_b = MulW'(scale_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start   = (cmd_i.op == DP_DIVA) || (cmd_i.op == DP_DIVT);
    div_num     = '0;
    div_den     = step_q.ws;
    step_we     = 1'b0;
    timed_we    = 1'b0;
    step_wdata  = '0;
    timed_wdata = '0;
    ram_addr    = AW'(elem_q);
    unique case (cmd_i.op)
      DP_CLEAR: begin
        ram_addr = clr_q;
        step_we  = 1'b1;
        timed_we = 1'b1;
      end
      DP_DIVA: begin
        div_num = (cmd_i.comp == 2'd0) ? {step_q.ss, 16'd0} : DivW'({vs_mag, 16'd0});
      end
      DP_DIVT: begin
        div_den = tt_q;
        div_num = (cmd_i.comp == 2'd0) ? DivW'(timed_q.ts) : DivW'(tv_mag);
      end
      DP_WSTEP: begin
        step_we    = 1'b1;
        step_wdata = step_q;
      end
      DP_STEPCLR: begin
        step_we = 1'b1;
      end
      DP_EMIT: begin
        step_we     = 1'b1;
        timed_we    = 1'b1;
        timed_wdata = timed_q;
      end
      default: ;
    endcase
  end

  tapt_ram #(.WIDTH($bits(step_t)), .DEPTH(NUM_ELEMENTS)) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (step_we),
    .addr_i  (ram_addr),
    .wdata_i (step_wdata),
    .rdata_o (step_rdata)
  );

  tapt_ram #(.WIDTH($bits(timed_t)), .DEPTH(NUM_ELEMENTS)) u_timed_ram (
    .clk_i   (clk_i),
    .we_i    (timed_we),
    .addr_i  (ram_addr),
    .wdata_i (timed_wdata),
    .rdata_o (timed_rdata)
  );

  tapt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      species_q    <= 8'd0;
      start_step_q <= 16'd1;
      scale_q      <= 32'd65536;
      tt_q         <= '0;
      active_q     <= 1'b0;
      clr_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.op == DP_EMIT;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SPECIES:    species_q    <= cfg_data_i[7:0];
          CFG_START_STEP: start_step_q <= cfg_data_i[15:0];
          CFG_SCALE:      scale_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == DP_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.op == DP_TSTEP) begin
        active_q <= stepn_q >= start_step_q;
        if (stepn_q >= start_step_q) begin
          tt_q <= tt_sum[32] ? '1 : tt_sum[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        op_q    <= operation_i;
        elem_q  <= element_index_i;
        spec_q  <= particle_species_i;
        w_q     <= particle_weight_i;
        v_q[0]  <= velocity_x_i;
        v_q[1]  <= velocity_y_i;
        v_q[2]  <= velocity_z_i;
        dt_q    <= step_length_i;
        stepn_q <= step_number_i;
      end
      DP_FETCH: begin
        step_q  <= step_rdata;
        timed_q <= timed_rdata;
        sq_q    <= '0;
        sqsum_q <= '0;
      end
      DP_WV, DP_AA, DP_SQLO, DP_DTLO, DP_SCHI: begin
        prod_q <= mul_p;
      end
      DP_VACC: begin
        prod_q <= mul_p;
        if (vacc > VsMax) begin
          step_q.vs[cmd_i.comp] <= VsumW'(VsMax);
        end else if (vacc < VsMin) begin
          step_q.vs[cmd_i.comp] <= VsumW'(VsMin);
        end else begin
          step_q.vs[cmd_i.comp] <= VsumW'(vacc);
        end
      end
      DP_SQACC: begin
        sq_q <= sq_q + SqW'(prod_q);
      end
      DP_SQHI, DP_DTHI, DP_SCLO: begin
        tlo_q  <= prod_q[63:0];
        prod_q <= mul_p;
      end
      DP_DEPFIN: begin
        step_q.ss <= sat_add_u(step_q.ss, pcomb);
        step_q.ws <= wsum[32] ? '1 : wsum[31:0];
      end
      DP_MEAN: begin
        if (cmd_i.comp == 2'd0 && div_quo[DivW-1:64] != '0) begin
          mval_q <= '1;
        end else begin
          mval_q <= div_quo[63:0];
        end
      end
      DP_TACC: begin
        if (cmd_i.comp == 2'd0) begin
          timed_q.ts <= sat_add_u(timed_q.ts, pcomb);
        end else begin
          timed_q.tv[vi] <= sat_add_s(timed_q.tv[vi],
                                      from_mag(step_q.vs[vi][VsumW-1], pcomb));
        end
      end
      DP_AVG: begin
        if (cmd_i.comp == 2'd0) begin
          msavg_q <= div_quo[63:0];
        end else begin
          a_q <= div_quo[63:0];
        end
      end
      DP_SQSUM: begin
        sqsum_q <= sat_add_u(sqsum_q, (a_q[63:32] != '0) ? '1 : 64'(prod_q[63:16]));
      end
      DP_TEMP: begin
        temp_q <= (tlo_q[63:32] != '0 || tsum[32]) ? '1 : tsum[31:0];
      end
      DP_ZTEMP: begin
        temp_q <= '0;
      end
      DP_EMIT: begin
        res_elem_q  <= elem_q;
        res_temp_q  <= temp_q;
        res_empty_q <= step_q.ws == '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.e_ok       = 17'(elem_q) < 17'(NUM_ELEMENTS);
    sts_o.species_ok = spec_q == species_q;
    sts_o.active     = active_q;
    sts_o.ws_zero    = step_q.ws == '0;
    sts_o.tt_zero    = tt_q == '0;
    sts_o.div_busy   = div_busy;
    sts_o.ms_gt      = msavg_q > sqsum_q;
    sts_o.clr_last   = clr_q == AW'(NUM_ELEMENTS - 1);
  end

  assign result_valid_o   = res_valid_q;
  assign result_element_o = res_elem_q;
  assign temperature_o    = res_temp_q;
  assign empty_step_o     = res_empty_q;

endmodule

// ----- src/tapt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Time averaged particle temperature: controller
// Sequences memory clearing, deposits, step starts and element finishing.
// ----------------------------------------------------------------------------
`include "time_averaged_particle_temperature_top_macros.svh"

module tapt_ctrl
  import tapt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FETCH, S_DWV, S_DVACC, S_DSQACC, S_DSQLO,
    S_DSQHI, S_DFIN, S_DWR, S_FCHK, S_FDIV, S_FDIVW, S_FMEAN, S_FDTLO,
    S_FDTHI, S_FTACC, S_FT, S_TDIV, S_TDIVW, S_TAVG, S_TAA, S_TSQ, S_CMP,
    S_SCHI, S_SCLO, S_TEMP, S_FZ, S_EMIT, S_SCLR
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] comp_q, comp_d;

  always_comb begin
    state_d     = state_q;
    comp_d      = comp_q;
    cmd_o.op    = DP_NOP;
    cmd_o.comp  = comp_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (sts_i.op)
          OP_START_STEP: cmd_o.op = DP_TSTEP;
          OP_DEPOSIT: begin
            if (sts_i.e_ok && sts_i.species_ok) state_d = S_FETCH;
          end
          OP_FINISH: begin
            if (sts_i.e_ok) state_d = sts_i.active ? S_FETCH : S_SCLR;
          end
          default: ;
        endcase
      end
      S_FETCH: begin
        cmd_o.op = DP_FETCH;
        comp_d   = 2'd0;
        state_d  = (sts_i.op == OP_DEPOSIT) ? S_DWV : S_FCHK;
      end
      S_DWV: begin
        cmd_o.op = DP_WV;
        state_d  = S_DVACC;
      end
      S_DVACC: begin
        cmd_o.op = DP_VACC;
        state_d  = S_DSQACC;
      end
      S_DSQACC: begin
        cmd_o.op = DP_SQACC;
        if (comp_q == 2'd2) begin
          comp_d  = 2'd0;
          state_d = S_DSQLO;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_DWV;
        end
      end
      S_DSQLO: begin
        cmd_o.op = DP_SQLO;
        state_d  = S_DSQHI;
      end
      S_DSQHI: begin
        cmd_o.op = DP_SQHI;
        state_d  = S_DFIN;
      end
      S_DFIN: begin
        cmd_o.op = DP_DEPFIN;
        state_d  = S_DWR;
      end
      S_DWR: begin
        cmd_o.op = DP_WSTEP;
        state_d  = S_IDLE;
      end
      S_FCHK: begin
        state_d = sts_i.ws_zero ? S_FT : S_FDIV;
      end
      S_FDIV: begin
        cmd_o.op = DP_DIVA;
        state_d  = S_FDIVW;
      end
      S_FDIVW: begin
        if (!sts_i.div_busy) state_d = S_FMEAN;
      end
      S_FMEAN: begin
        cmd_o.op = DP_MEAN;
        state_d  = S_FDTLO;
      end
      S_FDTLO: begin
        cmd_o.op = DP_DTLO;
        state_d  = S_FDTHI;
      end
      S_FDTHI: begin
        cmd_o.op = DP_DTHI;
        state_d  = S_FTACC;
      end
      S_FTACC: begin
        cmd_o.op = DP_TACC;
        if (comp_q == 2'd3) begin
          state_d = S_FT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_FDIV;
        end
      end
      S_FT: begin
        comp_d  = 2'd0;
        state_d = sts_i.tt_zero ? S_FZ : S_TDIV;
      end
      S_TDIV: begin
        cmd_o.op = DP_DIVT;
        state_d  = S_TDIVW;
      end
      S_TDIVW: begin
        if (!sts_i.div_busy) state_d = S_TAVG;
      end
      S_TAVG: begin
        cmd_o.op = DP_AVG;
        if (comp_q == 2'd0) begin
          comp_d  = 2'd1;
          state_d = S_TDIV;
        end else begin
          state_d = S_TAA;
        end
      end
      S_TAA: begin
        cmd_o.op = DP_AA;
        state_d  = S_TSQ;
      end
      S_TSQ: begin
        cmd_o.op = DP_SQSUM;
        if (comp_q == 2'd3) begin
          state_d = S_CMP;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_TDIV;
        end
      end
      S_CMP: begin
        state_d = sts_i.ms_gt ? S_SCHI : S_FZ;
      end
      S_SCHI: begin
        cmd_o.op = DP_SCHI;
        state_d  = S_SCLO;
      end
      S_SCLO: begin
        cmd_o.op = DP_SCLO;
        state_d  = S_TEMP;
      end
      S_TEMP: begin
        cmd_o.op = DP_TEMP;
        state_d  = S_EMIT;
      end
      S_FZ: begin
        cmd_o.op = DP_ZTEMP;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.op = DP_EMIT;
        state_d  = S_IDLE;
      end
      S_SCLR: begin
        cmd_o.op = DP_STEPCLR;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      comp_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

  `TAPT_ASSERT_NEXT(a_accept_decodes, state_q == S_IDLE && start_i, state_q == S_DECODE, "accepted item was not decoded")
  `TAPT_ASSERT_NEXT(a_div_launch, cmd_o.op == DP_DIVA || cmd_o.op == DP_DIVT, sts_i.div_busy, "divider did not start")
  `TAPT_ASSERT_NEXT(a_clear_holds, state_q == S_CLEAR && !sts_i.clr_last, state_q == S_CLEAR, "clear pass ended early")

endmodule

// ----- src/time_averaged_particle_temperature_top.sv -----
// ----------------------------------------------------------------------------
// Time averaged particle temperature: top level
// Per element kinetic temperature moments of one particle species.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Deposits add a
// particle to its element's step sums by a read-modify-write of the step
// sum memory, using the shared multiplier. A finish item runs up to eight
// divisions on the one bit per cycle divider. An inactive finish clears the
// step sums. A finish item while averaging is active gives one result on
// result_valid_o for exactly one cycle, rising in the same cycle that busy
// falls. The receiver has no way to stall it. Configuration writes on the
// cfg channel are always accepted; the user must make them only while the
// block is idle, as the block itself does not enforce this.
// After reset the block sweeps both sum memories to zero, one element per
// cycle, and holds busy high meanwhile.
// ----------------------------------------------------------------------------
module time_averaged_particle_temperature_top
  import tapt_pkg::*;
#(
  parameter int NUM_ELEMENTS   = 1024,
  parameter int VELOCITY_WIDTH = 16,
  parameter int WEIGHT_WIDTH   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic [1:0]                       operation_i,
  input  logic [9:0]                       element_index_i,
  input  logic [7:0]                       particle_species_i,
  input  logic [WEIGHT_WIDTH-1:0]          particle_weight_i,
  input  logic signed [VELOCITY_WIDTH-1:0] velocity_x_i,
  input  logic signed [VELOCITY_WIDTH-1:0] velocity_y_i,
  input  logic signed [VELOCITY_WIDTH-1:0] velocity_z_i,
  input  logic [15:0]                      step_length_i,
  input  logic [15:0]                      step_number_i,
  output logic                             result_valid_o,
  output logic [9:0]                       result_element_o,
  output logic [31:0]                      temperature_o,
  output logic                             empty_step_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tapt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  tapt_datapath #(
    .NUM_ELEMENTS   (NUM_ELEMENTS),
    .VELOCITY_WIDTH (VELOCITY_WIDTH),
    .WEIGHT_WIDTH   (WEIGHT_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .element_index_i    (element_index_i),
    .particle_species_i (particle_species_i),
    .particle_weight_i  (particle_weight_i),
    .velocity_x_i       (velocity_x_i),
    .velocity_y_i       (velocity_y_i),
    .velocity_z_i       (velocity_z_i),
    .step_length_i      (step_length_i),
    .step_number_i      (step_number_i),
    .result_valid_o     (result_valid_o),
    .result_element_o   (result_element_o),
    .temperature_o      (temperature_o),
    .empty_step_o       (empty_step_o)
  );

endmodule

// ----- bench/time_averaged_particle_temperature_top_tb.sv -----
// ----------------------------------------------------------------------------
// Time averaged particle temperature: testbench
// Drives deposit, start step and finish items through several register
// settings, predicts each reported temperature and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_averaged_particle_temperature_top_tb
  import tapt_pkg::*;
;

  localparam int NumElem = 1024;
  localparam int WatchLimit = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNKNOWN = 2'd3;
  localparam longint unsigned U64Max = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned U32Max = 64'hFFFF_FFFF;
  localparam longint VsumMax = 64'sd549755813887;

  typedef logic [127:0] wide_t;
  typedef logic signed [127:0] swide_t;

  typedef struct {
    logic [1:0]         op;
    logic [9:0]         elem;
    logic [7:0]         species;
    logic [15:0]        weight;
    logic signed [15:0] vel [3];
    logic [15:0]        dt;
    logic [15:0]        step_no;
  } item_t;

  typedef struct {
    logic [9:0]  elem;
    logic [31:0] temp;
    logic        empty;
  } temp_result_t;

  class temperature_scoreboard;
    logic [7:0]      species_sel;
    logic [15:0]     first_step;
    logic [31:0]     scale;
    longint unsigned weight_sum [NumElem];
    longint          vel_sum [3][NumElem];
    longint unsigned speed_sum [NumElem];
    longint unsigned timed_speed [NumElem];
    longint          timed_vel [3][NumElem];
    longint unsigned total_time;
    bit              active;
    temp_result_t    expected_temps[$];
    int              mismatches;
    int              results_seen;

    function new();
      species_sel = 0;
      first_step = 1;
      scale = 32'd65536;
      total_time = 0;
      active = 0;
      mismatches = 0;
      results_seen = 0;
      for (int e = 0; e < NumElem; e++) begin
        clear_elem(e);
        timed_speed[e] = 0;
        for (int k = 0; k < 3; k++) timed_vel[k][e] = 0;
      end
    endfunction

    function void clear_elem(int e);
      weight_sum[e] = 0;
      speed_sum[e] = 0;
      for (int k = 0; k < 3; k++) vel_sum[k][e] = 0;
    endfunction

    function longint unsigned sat_u(wide_t x);
      return (x > wide_t'(U64Max)) ? U64Max : x[63:0];
    endfunction

    function longint unsigned magnitude(longint x);
      longint unsigned m;
      m = x;
      return x < 0 ? -m : m;
    endfunction

    function longint sat_s(swide_t x);
      if (x > swide_t'(64'sh7FFF_FFFF_FFFF_FFFF)) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (x < -swide_t'(128'h8000_0000_0000_0000)) return 64'sh8000_0000_0000_0000;
      return x[63:0];
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SPECIES:    species_sel = data[7:0];
        CFG_START_STEP: first_step = data[15:0];
        CFG_SCALE:      scale = data;
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      int e;
      longint unsigned sq, w, ms, mv, ms_avg, sqsum, a, sqa, diff, temp;
      longint s, v;
      wide_t prod;
      e = int'(it.elem);
      w = 64'(it.weight);
      case (it.op)
        OP_START_STEP: begin
          active = it.step_no >= first_step;
          if (active) total_time = sat_u(wide_t'(total_time) + it.dt) > U32Max ?
                                   U32Max : total_time + it.dt;
        end
        OP_DEPOSIT: begin
          if (it.species == species_sel) begin
            weight_sum[e] = (weight_sum[e] + w > U32Max) ? U32Max : weight_sum[e] + w;
            sq = 0;
            for (int k = 0; k < 3; k++) begin
              v = it.vel[k];
              s = vel_sum[k][e] + longint'(w) * v;
              if (s > VsumMax) s = VsumMax;
              if (s < -VsumMax - 1) s = -VsumMax - 1;
              vel_sum[k][e] = s;
              sq += v * v;
            end
            prod = wide_t'(sq) * w;
            speed_sum[e] = sat_u(wide_t'(speed_sum[e]) + sat_u(prod));
          end
        end
        OP_FINISH: begin
          if (active) begin
            temp = 0;
            if (weight_sum[e] != 0) begin
              ms = sat_u((wide_t'(speed_sum[e]) << 16) / weight_sum[e]);
              timed_speed[e] = sat_u(wide_t'(timed_speed[e]) +
                                     sat_u(wide_t'(it.dt) * ms));
              for (int k = 0; k < 3; k++) begin
                mv = (magnitude(vel_sum[k][e]) << 16) / weight_sum[e];
                prod = wide_t'(sat_u(wide_t'(it.dt) * mv));
                timed_vel[k][e] = sat_s(swide_t'(timed_vel[k][e]) +
                  (vel_sum[k][e] < 0 ? -swide_t'(prod) : swide_t'(prod)));
              end
            end
            if (total_time != 0) begin
              ms_avg = timed_speed[e] / total_time;
              sqsum = 0;
              for (int k = 0; k < 3; k++) begin
                a = magnitude(timed_vel[k][e]) / total_time;
                sqa = (a > U32Max) ? U64Max : (a * a) >> 16;
                sqsum = sat_u(wide_t'(sqsum) + sqa);
              end
              if (ms_avg > sqsum) begin
                diff = ms_avg - sqsum;
                prod = (wide_t'(diff) * scale) >> 32;
                temp = (prod > wide_t'(U32Max)) ? U32Max : prod[63:0];
              end
            end
            expected_temps.push_back('{elem: it.elem, temp: temp[31:0],
                                       empty: weight_sum[e] == 0});
          end
          clear_elem(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [9:0] elem, logic [31:0] temp, logic empty);
      temp_result_t exp_r;
      results_seen++;
      if (expected_temps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: element %0d temp %0d", elem, temp);
        return;
      end
      exp_r = expected_temps.pop_front();
      if (elem !== exp_r.elem || temp !== exp_r.temp || empty !== exp_r.empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected elem %0d temp %0d empty %0b, got %0d %0d %0b",
                   exp_r.elem, exp_r.temp, exp_r.empty, elem, temp, empty);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic [1:0] operation_i = '0;
  logic [9:0] element_index_i = '0;
  logic [7:0] particle_species_i = '0;
  logic [15:0] particle_weight_i = '0;
  logic signed [15:0] velocity_x_i = '0;
  logic signed [15:0] velocity_y_i = '0;
  logic signed [15:0] velocity_z_i = '0;
  logic [15:0] step_length_i = '0;
  logic [15:0] step_number_i = '0;
  logic result_valid_o;
  logic [9:0] result_element_o;
  logic [31:0] temperature_o;
  logic empty_step_o;

  temperature_scoreboard sb = new();
  int idle_cycles = 0;
  int items_sent = 0;
  bit no_gaps = 0;

  time_averaged_particle_temperature_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        sb.note_item('{op: operation_i, elem: element_index_i, species: particle_species_i,
                       weight: particle_weight_i,
                       vel: '{velocity_x_i, velocity_y_i, velocity_z_i},
                       dt: step_length_i, step_no: step_number_i});
      end
      if (result_valid_o) begin
        sb.check_result(result_element_o, temperature_o, empty_step_o);
      end
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog expired with %0d results pending", sb.expected_temps.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_item(item_t it);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 6));
    repeat (gap) @(negedge clk_i);
    operation_i = it.op;
    element_index_i = it.elem;
    particle_species_i = it.species;
    particle_weight_i = it.weight;
    velocity_x_i = it.vel[0];
    velocity_y_i = it.vel[1];
    velocity_z_i = it.vel[2];
    step_length_i = it.dt;
    step_number_i = it.step_no;
    start = 1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 0;
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    while (sb.expected_temps.size() != 0 || busy) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  function automatic item_t make_item(logic [1:0] op, int elem, logic [7:0] sp,
                                      int w, int vx, int vy, int vz, int dt, int sn);
    item_t it;
    it.op = op;
    it.elem = 10'(elem);
    it.species = sp;
    it.weight = 16'(w);
    it.vel = '{16'(vx), 16'(vy), 16'(vz)};
    it.dt = 16'(dt);
    it.step_no = 16'(sn);
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = int'($urandom_range(0, 99));
    it.op = pick < 74 ? OP_DEPOSIT : pick < 84 ? OP_START_STEP :
            pick < 98 ? OP_FINISH : OP_UNUSED;
    it.elem = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, NumElem - 1)) :
              10'($urandom_range(0, 7));
    it.species = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : sb.species_sel;
    it.weight = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF) :
                16'($urandom());
    for (int k = 0; k < 3; k++)
      it.vel[k] = ($urandom_range(0, 2) == 0) ? 16'($urandom()) :
                  16'($urandom_range(0, 2000)) - 16'd1000 + 16'($urandom_range(0, 400));
    it.dt = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 100)) : 16'($urandom());
    it.step_no = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
                 (sb.first_step > 16'hFFF0 ? 16'hFFFF :
                  sb.first_step + 16'($urandom_range(0, 15)));
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_item(random_item());
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    write_reg(CFG_SPECIES, 32'd0);
    write_reg(CFG_START_STEP, 32'd10);
    write_reg(CFG_SCALE, 32'd65536);
    write_reg(CFG_UNKNOWN, 32'hFFFF_FFFF);

    // Averaging is still inactive: no result, step sums cleared.
    send_item(make_item(OP_DEPOSIT, 3, 0, 100, 5, 6, 7, 0, 0));
    send_item(make_item(OP_START_STEP, 0, 0, 0, 0, 0, 0, 50, 9));
    send_item(make_item(OP_FINISH, 3, 0, 0, 0, 0, 0, 10, 0));
    // Active with zero total time.
    send_item(make_item(OP_START_STEP, 0, 0, 0, 0, 0, 0, 0, 10));
    send_item(make_item(OP_DEPOSIT, 1, 0, 65535, -32768, 32767, -32768, 0, 0));
    send_item(make_item(OP_FINISH, 1, 0, 0, 0, 0, 0, 65535, 0));
    send_item(make_item(OP_START_STEP, 0, 0, 0, 0, 0, 0, 65535, 65535));
    // Extremes, other species, zero weight, unused operation.
    send_item(make_item(OP_DEPOSIT, 1023, 0, 65535, 32767, 32767, 32767, 0, 0));
    send_item(make_item(OP_DEPOSIT, 1023, 0, 65535, -32768, -32768, -32768, 0, 0));
    send_item(make_item(OP_DEPOSIT, 1023, 8'hFF, 500, 100, 100, 100, 0, 0));
    send_item(make_item(OP_DEPOSIT, 1023, 0, 0, 1000, 1000, 1000, 0, 0));
    send_item(make_item(OP_UNUSED, 1023, 0, 65535, 1, 1, 1, 65535, 65535));
    send_item(make_item(OP_FINISH, 1023, 0, 0, 0, 0, 0, 65535, 0));
    send_item(make_item(OP_FINISH, 1023, 0, 0, 0, 0, 0, 1, 0));
    send_item(make_item(OP_DEPOSIT, 0, 0, 1, 300, 0, 0, 0, 0));
    send_item(make_item(OP_DEPOSIT, 0, 0, 1, -300, 0, 0, 0, 0));
    send_item(make_item(OP_FINISH, 0, 0, 0, 0, 0, 0, 7, 0));
    send_item(make_item(OP_DEPOSIT, 2, 0, 10, 2000, 2000, 2000, 0, 0));
    send_item(make_item(OP_FINISH, 2, 0, 0, 0, 0, 0, 7, 0));

    random_phase(260);
    write_reg(CFG_SPECIES, 32'd255);
    write_reg(CFG_START_STEP, 32'd65535);
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    random_phase(260);
    write_reg(CFG_SPECIES, $urandom());
    write_reg(CFG_START_STEP, 32'd0);
    write_reg(CFG_SCALE, 32'd0);
    random_phase(60);
    write_reg(CFG_SCALE, 32'h0003_8000);
    random_phase(250);

    while (sb.expected_temps.size() != 0 || busy) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("Run covered %0d items and %0d temperature results over four register settings.",
             items_sent, sb.results_seen);
    if (sb.mismatches == 0 && sb.expected_temps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.expected_temps.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
